// ----- rtl/eabv_pkg.sv -----
// ----------------------------------------------------------------------------
// eabv_pkg: shared constants for the Euler angle to basis vector core
// Fixed-point formats, CORDIC arctangent table and gain constant.
// ----------------------------------------------------------------------------
package eabv_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned WorkFrac    = 30;
  localparam int unsigned WorkBits    = 34;   // signed, covers |x| < 2^33
  localparam int unsigned ZBits       = 33;
  localparam int unsigned FieldBits   = 16;
  localparam int unsigned InBytes     = 6;
  localparam int unsigned OutBytes    = 18;

  localparam logic signed [WorkBits-1:0] GainInv = 34'sd652032874;

  typedef logic signed [WorkBits-1:0] work_t;
  typedef logic signed [ZBits-1:0]    zang_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic zang_t atan_turn(input logic [4:0] i);
    zang_t r;
    case (i)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/euler_angles_to_basis_vectors_core.sv -----
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_core
// Pitch/yaw/roll binary angles in, forward/right/up unit vectors out (Q1.F).
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled.
// Stages: one input stage, thirty CORDIC iterations, a quadrant stage,
// two multiply levels each with a rounding stage, an add stage and an
// output saturation stage. A stall on the output freezes the whole pipe.
module euler_angles_to_basis_vectors_core
  import eabv_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // pitch_angle[15:0], yaw_angle[31:16], roll_angle[47:32]
  input  logic [8*InBytes-1:0]    s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // forward_x, forward_y, forward_z, right_x, right_y, right_z,
  // up_x, up_y, up_z: 16 bits each from bit 0 up
  output logic [8*OutBytes-1:0]   m_axis_tdata
);

  localparam int unsigned Depth   = CordicSteps + 8;
  localparam int unsigned Shift   = WorkFrac - FRACTION_BITS;
  localparam int unsigned QBits   = 2;

  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // ---------------- CORDIC iterations, one per stage ----------------
  work_t            cx_q [CordicSteps+1][3];
  work_t            cy_q [CordicSteps+1][3];
  zang_t            cz_q [CordicSteps+1][3];
  logic [QBits-1:0] cq_q [CordicSteps+1][3];

  // ---------------- stage 0: fold angles into quadrant ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [31:0] f;
        logic [31:0] a;
        logic [31:0] rem;
        logic [1:0]  q;
        f   = 32'(s_axis_tdata[FieldBits*k +: FieldBits]);
        // bits above ANGLE_BITS fall off the top
        a   = f << (32 - ANGLE_BITS);
        q   = 2'((a + 32'h2000_0000) >> 30);
        rem = a - {q, 30'd0};
        cx_q[0][k] <= GainInv;
        cy_q[0][k] <= '0;
        cq_q[0][k] <= q;
        cz_q[0][k] <= {rem[31], rem};
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          work_t xs, ys;
          xs = cx_q[i][k] >>> i;
          ys = cy_q[i][k] >>> i;
          if (!cz_q[i][k][ZBits-1]) begin
            cx_q[i+1][k] <= cx_q[i][k] - ys;
            cy_q[i+1][k] <= cy_q[i][k] + xs;
            cz_q[i+1][k] <= cz_q[i][k] - atan_turn(5'(i));
          end else begin
            cx_q[i+1][k] <= cx_q[i][k] + ys;
            cy_q[i+1][k] <= cy_q[i][k] - xs;
            cz_q[i+1][k] <= cz_q[i][k] + atan_turn(5'(i));
          end
          cq_q[i+1][k] <= cq_q[i][k];
        end
      end
    end
  end

  // ---------------- quadrant fix: sine and cosine ----------------
  work_t sn_q [3];
  work_t cs_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        case (cq_q[CordicSteps][k])
          2'd0: begin
            cs_q[k] <= cx_q[CordicSteps][k];  sn_q[k] <= cy_q[CordicSteps][k];
          end
          2'd1: begin
            cs_q[k] <= -cy_q[CordicSteps][k]; sn_q[k] <= cx_q[CordicSteps][k];
          end
          2'd2: begin
            cs_q[k] <= -cx_q[CordicSteps][k]; sn_q[k] <= -cy_q[CordicSteps][k];
          end
          default: begin
            cs_q[k] <= cy_q[CordicSteps][k];  sn_q[k] <= -cx_q[CordicSteps][k];
          end
        endcase
      end
    end
  end

  // p = 0, y = 1, r = 2
  function automatic work_t rnd(input logic signed [2*WorkBits-1:0] p);
    logic signed [2*WorkBits-1:0] t;
    t = (p + (68'sd1 <<< (WorkFrac-1))) >>> WorkFrac;
    return t[WorkBits-1:0];
  endfunction

  // ---------------- level 1 products ----------------
  // m1: ss=sr*sp, crsp=cr*sp, cpcy, cpsy, srcp, crcp, crsy, srsy, srcy, crcy
  localparam int unsigned M1 = 10;
  logic signed [2*WorkBits-1:0] p1_q [M1];
  work_t sy1_q, cy1_q, sp1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= sn_q[2] * sn_q[0];
      p1_q[1] <= cs_q[2] * sn_q[0];
      p1_q[2] <= cs_q[0] * cs_q[1];
      p1_q[3] <= cs_q[0] * sn_q[1];
      p1_q[4] <= sn_q[2] * cs_q[0];
      p1_q[5] <= cs_q[2] * cs_q[0];
      p1_q[6] <= cs_q[2] * sn_q[1];
      p1_q[7] <= sn_q[2] * sn_q[1];
      p1_q[8] <= sn_q[2] * cs_q[1];
      p1_q[9] <= cs_q[2] * cs_q[1];
      sy1_q   <= sn_q[1];
      cy1_q   <= cs_q[1];
      sp1_q   <= sn_q[0];
    end
  end

  work_t r1_q [M1];
  work_t sy2_q, cy2_q, sp2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < M1; j++) r1_q[j] <= rnd(p1_q[j]);
      sy2_q <= sy1_q;
      cy2_q <= cy1_q;
      sp2_q <= sp1_q;
    end
  end

  // ---------------- level 2 products ----------------
  // ss*cy, ss*sy, crsp*cy, crsp*sy
  logic signed [2*WorkBits-1:0] p2_q [4];
  work_t k2_q [M1];
  work_t sp3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q[0] <= r1_q[0] * cy2_q;
      p2_q[1] <= r1_q[0] * sy2_q;
      p2_q[2] <= r1_q[1] * cy2_q;
      p2_q[3] <= r1_q[1] * sy2_q;
      k2_q    <= r1_q;
      sp3_q   <= sp2_q;
    end
  end

  work_t r2_q [4];
  work_t k3_q [M1];
  work_t sp4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) r2_q[j] <= rnd(p2_q[j]);
      k3_q  <= k2_q;
      sp4_q <= sp3_q;
    end
  end

  // ---------------- sums ----------------
  work_t v_q [9];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q[0] <= k3_q[2];
      v_q[1] <= k3_q[3];
      v_q[2] <= -sp4_q;
      v_q[3] <= -r2_q[0] + k3_q[6];
      v_q[4] <= -r2_q[1] - k3_q[9];
      v_q[5] <= -k3_q[4];
      v_q[6] <= r2_q[2] + k3_q[7];
      v_q[7] <= r2_q[3] - k3_q[8];
      v_q[8] <= k3_q[5];
    end
  end

  // ---------------- round, saturate, output register ----------------
  logic [8*OutBytes-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        work_t t;
        work_t one;
        one = work_t'(1) <<< FRACTION_BITS;
        if (Shift > 0) t = (v_q[j] + (work_t'(1) <<< (Shift-1))) >>> Shift;
        else           t = v_q[j];
        if (t > one)  t = one;
        if (t < -one) t = -one;
        out_q[FieldBits*j +: FieldBits] <= t[FieldBits-1:0];
      end
    end
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pipe stalled with empty output");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at entry");
`endif

endmodule
